>>> rtl/aths_pkg.sv
// aths_pkg: shared constants, types and hash helpers for the allocation tracking hash set
// used by aths_slot_store, aths_probe_ctrl and allocation_tracking_hash_set
// no dependencies
package aths_pkg;

   // table geometry
   localparam int TABLE_BITS  = 10;
   localparam int SLOT_COUNT  = 1 << TABLE_BITS;
   localparam int CNT_W       = TABLE_BITS + 1;

   // field widths
   localparam int KEY_W       = 48;
   localparam int SIZE_W      = 32;
   localparam int BYTES_W     = 33;
   localparam int LIVE_W      = 11;
   localparam int STATUS_W    = 3;
   localparam int LIMIT_W     = 13;
   localparam int REQ_DATA_W  = 80;
   localparam int RSP_DATA_W  = 48;

   // hashing and probing
   localparam int HASH_MUL    = 73;
   localparam int PROBE_STEP  = 5009;

   // load limit: refuse when 20 * occupancy >= 17 * slot count
   localparam int OCC_W       = CNT_W + 1;
   localparam int OCC_SCL_W   = TABLE_BITS + 8;
   localparam int LOAD_NUM    = 20;
   localparam int LOAD_LIMIT  = 17 * SLOT_COUNT;

   // limit register reset value in MiB
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);
   localparam int MIB_SHIFT   = 20;

   // special key codes
   localparam logic [KEY_W-1:0] KEY_EMPTY = '0;
   localparam logic [KEY_W-1:0] KEY_TOMB  = KEY_W'(1);

   typedef logic [TABLE_BITS-1:0] slot_idx_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_REFUSED    = 3'd1,
      ST_NOT_FOUND  = 3'd2,
      ST_NO_MEMORY  = 3'd3,
      ST_TABLE_FULL = 3'd4
   } status_type;

   // memory access from the controller
   typedef struct packed {
      slot_idx_type          rd_addr;
      slot_idx_type          wr_addr;
      logic                  key_we;
      logic [KEY_W-1:0]      key_wdata;
      logic                  size_we;
      logic [SIZE_W-1:0]     size_wdata;
   } slot_req_type;

   // registered read data from the memories
   typedef struct packed {
      logic [KEY_W-1:0]      key;
      logic [SIZE_W-1:0]     size;
   } slot_rsp_type;

   // one finished result
   typedef struct packed {
      status_type            status;
      logic [BYTES_W-1:0]    bytes;
      logic [LIVE_W-1:0]     live;
   } result_type;

   // home slot: only the low index bits of key * 73 matter
   function automatic slot_idx_type home_slot(input logic [KEY_W-1:0] key);
      slot_idx_type prod;
      prod = key[TABLE_BITS-1:0] * TABLE_BITS'(HASH_MUL);
      return prod;
   endfunction

   // next slot of a probe sequence
   function automatic slot_idx_type next_slot(input slot_idx_type idx);
      return idx + TABLE_BITS'(PROBE_STEP);
   endfunction

endpackage

>>> rtl/aths_slot_store.sv
// aths_slot_store: key and size memories of the hash set, one write and one read port each
// depends on aths_pkg
// read data is registered, available in the cycle after the read address
module aths_slot_store
   import aths_pkg::*;
(
   input  logic         clock,
   input  slot_req_type slot_req,
   output slot_rsp_type slot_rsp
);

   logic [KEY_W-1:0]  keys  [SLOT_COUNT];
   logic [SIZE_W-1:0] sizes [SLOT_COUNT];

   logic [KEY_W-1:0]  key_rd_ff;
   logic [SIZE_W-1:0] size_rd_ff;

   // key memory
   always_ff @(posedge clock) begin
      if (slot_req.key_we) begin
         keys[slot_req.wr_addr] <= slot_req.key_wdata;
      end
      key_rd_ff <= keys[slot_req.rd_addr];
   end

   // size memory
   always_ff @(posedge clock) begin
      if (slot_req.size_we) begin
         sizes[slot_req.wr_addr] <= slot_req.size_wdata;
      end
      size_rd_ff <= sizes[slot_req.rd_addr];
   end

   assign slot_rsp.key  = key_rd_ff;
   assign slot_rsp.size = size_rd_ff;

endmodule

>>> rtl/aths_probe_ctrl.sv
// aths_probe_ctrl: request sequencer, probes the slot memories and keeps the counters
// depends on aths_pkg; drives aths_slot_store through slot_req_type
// one memory read per cycle, writes only during the clearing pass and in the final probe cycle
module aths_probe_ctrl
   import aths_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request transaction
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_mode,
   input  logic [KEY_W-1:0]    req_key,
   input  logic [SIZE_W-1:0]   req_size,
   // byte limit in MiB
   input  logic [LIMIT_W-1:0]  limit_mib,
   // memories
   output slot_req_type        slot_req,
   input  slot_rsp_type        slot_rsp,
   // finished result
   output logic                res_valid,
   input  logic                res_ready,
   output result_type          result
);

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_START = 5'b00100,
      S_PROBE = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic                mode_ff, mode_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   slot_idx_type        idx_ff, idx_in;
   logic [CNT_W-1:0]    probes_ff, probes_in;
   logic [CNT_W-1:0]    live_ff, live_in;
   logic [CNT_W-1:0]    tomb_ff, tomb_in;
   logic [BYTES_W-1:0]  bytes_ff, bytes_in;
   status_type          status_ff, status_in;
   slot_idx_type        clr_ff, clr_in;

   logic                key_reserved;
   logic                over_limit;
   logic [BYTES_W:0]    bytes_sum;
   logic [BYTES_W:0]    limit_bytes;
   logic [OCC_W-1:0]    occupancy;
   logic [OCC_SCL_W-1:0] occ_scaled;
   logic                load_full;
   logic                last_probe;
   logic [BYTES_W-1:0]  rd_size_ext;
   logic                rd_free;

   // checks done before probing
   assign key_reserved = (key_ff == KEY_EMPTY) || (key_ff == KEY_TOMB);
   assign bytes_sum    = {1'b0, bytes_ff} + (BYTES_W + 1)'(size_ff);
   assign limit_bytes  = (BYTES_W + 1)'({limit_mib, MIB_SHIFT'(0)});
   assign over_limit   = bytes_sum >= limit_bytes;

   // load limit for filling an empty slot
   assign occupancy  = OCC_W'(live_ff) + OCC_W'(tomb_ff) + OCC_W'(1);
   assign occ_scaled = OCC_SCL_W'(occupancy) * OCC_SCL_W'(LOAD_NUM);
   assign load_full  = occ_scaled >= OCC_SCL_W'(LOAD_LIMIT);

   assign last_probe  = probes_ff == CNT_W'(SLOT_COUNT - 1);
   assign rd_size_ext = BYTES_W'(slot_rsp.size);
   assign rd_free     = (slot_rsp.key == KEY_EMPTY) || (slot_rsp.key == KEY_TOMB);

   // sequencer
   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      key_in     = key_ff;
      size_in    = size_ff;
      idx_in     = idx_ff;
      probes_in  = probes_ff;
      live_in    = live_ff;
      tomb_in    = tomb_ff;
      bytes_in   = bytes_ff;
      status_in  = status_ff;
      clr_in     = clr_ff;

      slot_req.rd_addr    = idx_in;
      slot_req.wr_addr    = idx_ff;
      slot_req.key_we     = 1'b0;
      slot_req.key_wdata  = key_ff;
      slot_req.size_we    = 1'b0;
      slot_req.size_wdata = size_ff;

      case (state_ff)
         // clearing pass over the key memory after reset
         S_CLEAR: begin
            slot_req.wr_addr   = clr_ff;
            slot_req.key_we    = 1'b1;
            slot_req.key_wdata = KEY_EMPTY;
            clr_in = clr_ff + TABLE_BITS'(1);
            if (clr_ff == slot_idx_type'(SLOT_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               mode_in  = req_mode;
               key_in   = req_key;
               size_in  = req_size;
               state_in = S_START;
            end
         end
         // limit and key checks, read of the home slot
         S_START: begin
            idx_in    = home_slot(key_ff);
            probes_in = '0;
            if (!mode_ff && over_limit) begin
               status_in = ST_NO_MEMORY;
               state_in  = S_DONE;
            end else if (key_reserved) begin
               status_in = ST_REFUSED;
               state_in  = S_DONE;
            end else begin
               state_in = S_PROBE;
            end
            slot_req.rd_addr = idx_in;
         end
         // one slot per cycle, next read issued while this one is checked
         S_PROBE: begin
            if (!mode_ff) begin
               if (rd_free) begin
                  if ((slot_rsp.key == KEY_EMPTY) && load_full) begin
                     status_in = ST_TABLE_FULL;
                  end else begin
                     slot_req.key_we  = 1'b1;
                     slot_req.size_we = 1'b1;
                     if ((slot_rsp.key == KEY_TOMB) && (tomb_ff != '0)) begin
                        tomb_in = tomb_ff - CNT_W'(1);
                     end
                     live_in   = live_ff + CNT_W'(1);
                     bytes_in  = bytes_ff + BYTES_W'(size_ff);
                     status_in = ST_OK;
                  end
                  state_in = S_DONE;
               end else if (slot_rsp.key == key_ff) begin
                  status_in = ST_REFUSED;
                  state_in  = S_DONE;
               end else if (last_probe) begin
                  status_in = ST_TABLE_FULL;
                  state_in  = S_DONE;
               end else begin
                  idx_in    = next_slot(idx_ff);
                  probes_in = probes_ff + CNT_W'(1);
               end
            end else begin
               if (slot_rsp.key == KEY_EMPTY) begin
                  status_in = ST_NOT_FOUND;
                  state_in  = S_DONE;
               end else if (slot_rsp.key == key_ff) begin
                  slot_req.key_we    = 1'b1;
                  slot_req.key_wdata = KEY_TOMB;
                  if (live_ff != '0) begin
                     live_in = live_ff - CNT_W'(1);
                  end
                  tomb_in   = tomb_ff + CNT_W'(1);
                  bytes_in  = (bytes_ff >= rd_size_ext) ? bytes_ff - rd_size_ext : '0;
                  status_in = ST_OK;
                  state_in  = S_DONE;
               end else if (last_probe) begin
                  status_in = ST_NOT_FOUND;
                  state_in  = S_DONE;
               end else begin
                  idx_in    = next_slot(idx_ff);
                  probes_in = probes_ff + CNT_W'(1);
               end
            end
            slot_req.rd_addr = idx_in;
         end
         // hand the result over once the output register is free
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         live_ff  <= '0;
         tomb_ff  <= '0;
         bytes_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         live_ff  <= live_in;
         tomb_ff  <= tomb_in;
         bytes_ff <= bytes_in;
      end
   end

   // transaction payload and probe position
   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      key_ff    <= key_in;
      size_ff   <= size_in;
      idx_ff    <= idx_in;
      probes_ff <= probes_in;
      status_ff <= status_in;
   end

   assign req_ready     = state_ff == S_IDLE;
   assign res_valid     = state_ff == S_DONE;
   assign result.status = status_ff;
   assign result.bytes  = bytes_ff;
   assign result.live   = LIVE_W'(live_ff);

endmodule

>>> rtl/allocation_tracking_hash_set.sv
// Allocation tracking hash set. Each request transaction registers or releases one
// allocation block in an open-addressed table of 2^TABLE_BITS slots (1024) held in
// two memories with registered reads, keys and sizes. A request is checked for a
// reserved key and, when registering, against the byte limit while its home slot is
// read, then probes one slot per cycle (bounded by the slot memory read port);
// requests refused by the byte limit or for a reserved key skip the probing. One
// request is worked on at a time, but the next one is accepted while a result still
// waits in the output register. After reset the block clears all 2^TABLE_BITS slots
// (1024) of the key memory with req_tready low; csr writes are taken during it.
// depends on aths_pkg, aths_slot_store and aths_probe_ctrl
module allocation_tracking_hash_set
   import aths_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // block_address[47:0], block_size[79:48]
   input  logic                   req_tuser,   // mode[0]
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // status[2:0], bytes_in_use[35:3],
                                               // live_count[46:36], zero[47]
   // configuration
   input  logic                   csr_wr_en,
   input  logic [LIMIT_W-1:0]     csr_wr_data  // memory_limit_mib
);

   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_data_ff, rsp_data_in;

   slot_req_type       slot_req;
   slot_rsp_type       slot_rsp;
   logic               res_valid;
   logic               res_ready;
   result_type         result;

   aths_slot_store u_store (
      .clock    (clock),
      .slot_req (slot_req),
      .slot_rsp (slot_rsp)
   );

   aths_probe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_mode  (req_tuser),
      .req_key   (req_tdata[KEY_W-1:0]),
      .req_size  (req_tdata[KEY_W+SIZE_W-1:KEY_W]),
      .limit_mib (limit_ff),
      .slot_req  (slot_req),
      .slot_rsp  (slot_rsp),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .result    (result)
   );

   // limit register
   assign limit_in = csr_wr_en ? csr_wr_data : limit_ff;

   // output register, free when empty or being drained
   assign res_ready    = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = res_valid ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   assign rsp_data_in  = (res_valid && res_ready) ? result : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff.live, rsp_data_ff.bytes, rsp_data_ff.status};

endmodule

>>> dv/tb_allocation_tracking_hash_set.sv
// tb_allocation_tracking_hash_set: self-checking bench for the allocation tracking hash set,
// a directed table followed by random register/release traffic checked by a shadow table
// depends on aths_pkg and allocation_tracking_hash_set
module tb_allocation_tracking_hash_set;
   import aths_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 9;
   localparam int TAIL_CYCLES    = 64;
   localparam int CYCLE_LIMIT    = 10_000_000;
   localparam int DIRECTED_COUNT = 21;
   localparam int PHASE_COUNT    = 5;
   localparam int REPORT_MAX     = 10;

   localparam logic MODE_REGISTER = 1'b0;
   localparam logic MODE_RELEASE  = 1'b1;

   typedef struct {
      logic              mode;
      logic [KEY_W-1:0]  addr;
      logic [SIZE_W-1:0] size;
      bit                typed;
      result_type        want;
   } directed_row_type;

   typedef struct {
      logic [LIMIT_W-1:0] limit_mib;
      int                 items;
      int                 register_pct;
      int                 wide_size_pct;
   } phase_type;

   // dut ports
   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;   // block_address[47:0], block_size[79:48]
   logic                  req_tuser   = 1'b0; // mode[0]
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // status[2:0], bytes_in_use[35:3],
                                              // live_count[46:36], zero[47]
   logic                  csr_wr_en   = 1'b0;
   logic [LIMIT_W-1:0]    csr_wr_data = '0;   // memory_limit_mib

   // shadow copy of the table and its counters
   logic [KEY_W-1:0]   shadow_keys  [SLOT_COUNT];
   logic [SIZE_W-1:0]  shadow_sizes [SLOT_COUNT];
   int                 shadow_live;
   int                 shadow_tombs;
   logic [BYTES_W-1:0] shadow_bytes;
   logic [LIMIT_W-1:0] shadow_limit_mib;

   result_type        pending_results [$];
   logic [KEY_W-1:0]  live_addrs [$];
   int                mismatch_count = 0;
   int                cycle_count    = 0;
   int                burst_left     = 0;

   logic [15:0] ready_pattern = '1;
   logic [3:0]  ready_phase   = '0;
   int          ready_hold    = 0;

   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      // empty table, reserved keys, limit checked before the key
      '{MODE_RELEASE,  48'h0000_0000_0100, 32'd0,         1'b1, '{ST_NOT_FOUND, 33'd0, 11'd0}},
      '{MODE_REGISTER, 48'h0000_0000_0000, 32'd5,         1'b1, '{ST_REFUSED, 33'd0, 11'd0}},
      '{MODE_REGISTER, 48'h0000_0000_0001, 32'hFFFF_FFFF, 1'b1, '{ST_NO_MEMORY, 33'd0, 11'd0}},
      '{MODE_REGISTER, 48'h0000_0000_0001, 32'd9,         1'b1, '{ST_REFUSED, 33'd0, 11'd0}},
      '{MODE_RELEASE,  48'h0000_0000_0000, 32'd0,         1'b1, '{ST_REFUSED, 33'd0, 11'd0}},
      '{MODE_RELEASE,  48'h0000_0000_0001, 32'hFFFF_FFFF, 1'b1, '{ST_REFUSED, 33'd0, 11'd0}},
      // widest key and size
      '{MODE_REGISTER, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{ST_NO_MEMORY, 33'd0, 11'd0}},
      '{MODE_REGISTER, 48'hFFFF_FFFF_FFFF, 32'd0,         1'b1, '{ST_OK, 33'd0, 11'd1}},
      '{MODE_REGISTER, 48'hFFFF_FFFF_FFFF, 32'd10,        1'b1, '{ST_REFUSED, 33'd0, 11'd1}},
      // two keys sharing home slot 0, then a copy placed in the tombstone ahead of the original
      '{MODE_REGISTER, 48'h0000_0000_0400, 32'd100,       1'b0, '{ST_OK, 33'd0, 11'd0}},
      '{MODE_REGISTER, 48'h8000_0000_0800, 32'd200,       1'b0, '{ST_OK, 33'd0, 11'd0}},
      '{MODE_RELEASE,  48'h0000_0000_0400, 32'd0,         1'b0, '{ST_OK, 33'd0, 11'd0}},
      '{MODE_REGISTER, 48'h8000_0000_0800, 32'd7,         1'b0, '{ST_OK, 33'd0, 11'd0}},
      '{MODE_RELEASE,  48'h8000_0000_0800, 32'd0,         1'b0, '{ST_OK, 33'd0, 11'd0}},
      '{MODE_RELEASE,  48'h8000_0000_0800, 32'd0,         1'b0, '{ST_OK, 33'd0, 11'd0}},
      '{MODE_RELEASE,  48'h8000_0000_0800, 32'd0,         1'b0, '{ST_OK, 33'd0, 11'd0}},
      // byte limit boundary at the reset limit
      '{MODE_REGISTER, 48'h0000_0000_0002, 32'h3FFF_FFFF, 1'b0, '{ST_OK, 33'd0, 11'd0}},
      '{MODE_REGISTER, 48'h0000_0000_0003, 32'd1,         1'b0, '{ST_OK, 33'd0, 11'd0}},
      '{MODE_REGISTER, 48'h0000_0000_0003, 32'd0,         1'b0, '{ST_OK, 33'd0, 11'd0}},
      '{MODE_RELEASE,  48'h0000_0000_0002, 32'd0,         1'b0, '{ST_OK, 33'd0, 11'd0}},
      '{MODE_RELEASE,  48'hFFFF_FFFF_FFFF, 32'd0,         1'b0, '{ST_OK, 33'd0, 11'd0}}
   };

   phase_type phases [PHASE_COUNT] = '{
      '{13'd4096, 950, 80, 1},
      '{13'd64,   150, 40, 0},
      '{13'd0,     50, 60, 5},
      '{13'h1FFF, 450, 75, 15},
      '{13'd4096, 200, 60, 2}
   };

   allocation_tracking_hash_set dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // shadow table update for one accepted request, returns the expected result
   function automatic result_type track_request(input logic mode,
                                                input logic [KEY_W-1:0] addr,
                                                input logic [SIZE_W-1:0] size);
      result_type    res;
      status_type    st;
      slot_idx_type  idx;
      logic [63:0]   limit_bytes;
      int            n;
      limit_bytes = 64'(shadow_limit_mib) << MIB_SHIFT;
      idx = slot_idx_type'(addr * KEY_W'(HASH_MUL));
      n = 0;
      if (mode == MODE_REGISTER) begin
         if (64'(shadow_bytes) + 64'(size) >= limit_bytes) begin
            st = ST_NO_MEMORY;
         end else if (addr == KEY_EMPTY || addr == KEY_TOMB) begin
            st = ST_REFUSED;
         end else begin
            // insert probe stops at the first free slot of either kind
            while (n < SLOT_COUNT && shadow_keys[idx] != KEY_EMPTY &&
                   shadow_keys[idx] != KEY_TOMB && shadow_keys[idx] != addr) begin
               idx = idx + slot_idx_type'(PROBE_STEP);
               n++;
            end
            if (n == SLOT_COUNT) begin
               st = ST_TABLE_FULL;
            end else if (shadow_keys[idx] == addr) begin
               st = ST_REFUSED;
            end else if (shadow_keys[idx] == KEY_EMPTY &&
                         20 * (shadow_live + shadow_tombs + 1) >= 17 * SLOT_COUNT) begin
               st = ST_TABLE_FULL;
            end else begin
               if (shadow_keys[idx] == KEY_TOMB && shadow_tombs > 0)
                  shadow_tombs--;
               shadow_keys[idx]  = addr;
               shadow_sizes[idx] = size;
               shadow_live++;
               shadow_bytes = shadow_bytes + BYTES_W'(size);
               st = ST_OK;
            end
         end
      end else begin
         st = ST_NOT_FOUND;
         if (addr == KEY_EMPTY || addr == KEY_TOMB) begin
            st = ST_REFUSED;
         end else begin
            // release probe runs until an empty slot, skipping tombstones
            for (n = 0; n < SLOT_COUNT; n++) begin
               if (shadow_keys[idx] == KEY_EMPTY)
                  break;
               if (shadow_keys[idx] == addr) begin
                  shadow_keys[idx] = KEY_TOMB;
                  if (shadow_live > 0)
                     shadow_live--;
                  shadow_tombs++;
                  if (shadow_bytes >= BYTES_W'(shadow_sizes[idx]))
                     shadow_bytes = shadow_bytes - BYTES_W'(shadow_sizes[idx]);
                  else
                     shadow_bytes = '0;
                  st = ST_OK;
                  break;
               end
               idx = idx + slot_idx_type'(PROBE_STEP);
            end
         end
      end
      res.status = st;
      res.bytes  = shadow_bytes;
      res.live   = LIVE_W'(shadow_live);
      return res;
   endfunction

   // random address, a fifth of them crowded onto a few home slots
   function automatic logic [KEY_W-1:0] draw_address();
      logic [KEY_W-1:0] addr;
      addr = KEY_W'({$urandom, $urandom});
      if ($urandom_range(0, 4) == 0)
         addr[TABLE_BITS-1:0] = TABLE_BITS'($urandom_range(0, 7));
      return addr;
   endfunction

   function automatic logic [SIZE_W-1:0] draw_size(input int wide_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < wide_pct)
         return $urandom;
      else if (roll < wide_pct + 30)
         return $urandom_range(0, 1 << 20);
      else
         return $urandom_range(0, 4095);
   endfunction

   // drive one request transaction, record its expected result, then maybe idle
   task automatic send_request(input logic mode, input logic [KEY_W-1:0] addr,
                               input logic [SIZE_W-1:0] size, input bit typed,
                               input result_type want);
      result_type predicted;
      int         gap;
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {size, addr};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predicted = track_request(mode, addr, size);
      pending_results.push_back(typed ? want : predicted);
      // keep a list of live addresses so releases mostly hit
      if (predicted.status == ST_OK) begin
         if (mode == MODE_REGISTER) begin
            live_addrs.push_back(addr);
         end else begin
            foreach (live_addrs[i]) begin
               if (live_addrs[i] == addr) begin
                  live_addrs.delete(i);
                  break;
               end
            end
         end
      end
      // bursts of back-to-back requests with random gaps between them
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 23);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic random_request(input phase_type ph);
      logic             mode;
      logic [KEY_W-1:0] addr;
      logic [SIZE_W-1:0] size;
      int               roll;
      result_type       unused;
      unused = '{ST_OK, '0, '0};
      roll = $urandom_range(0, 99);
      size = draw_size(ph.wide_size_pct);
      if (roll < ph.register_pct) begin
         mode = MODE_REGISTER;
         if (live_addrs.size() != 0 && $urandom_range(0, 9) == 0)
            addr = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
         else
            addr = draw_address();
      end else if (roll < ph.register_pct + 5) begin
         // noise on the reserved keys
         mode = 1'($urandom);
         addr = KEY_W'($urandom_range(0, 1));
         size = $urandom;
      end else begin
         mode = MODE_RELEASE;
         if (live_addrs.size() != 0 && $urandom_range(0, 4) != 0)
            addr = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
         else
            addr = draw_address();
      end
      send_request(mode, addr, size, 1'b0, unused);
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      shadow_limit_mib = value;
   endtask

   // receiver stall pattern, reshuffled now and then, sometimes always ready
   always @(posedge clock) begin
      if (ready_hold == 0) begin
         ready_hold    <= $urandom_range(16, 96);
         ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h1);
      end else begin
         ready_hold <= ready_hold - 1;
      end
      rsp_tready  <= ready_pattern[ready_phase];
      ready_phase <= ready_phase + 4'd1;
   end

   // compare each result transaction with the oldest expectation
   always @(posedge clock) begin : result_check
      result_type         want;
      logic [STATUS_W-1:0] got_status;
      logic [BYTES_W-1:0]  got_bytes;
      logic [LIVE_W-1:0]   got_live;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_status = rsp_tdata[2:0];
         got_bytes  = rsp_tdata[35:3];
         got_live   = rsp_tdata[46:36];
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("%0t: unexpected result status %0d bytes %0d live %0d",
                        $realtime, got_status, got_bytes, got_live);
         end else begin
            want = pending_results.pop_front();
            if (got_status != want.status || got_bytes != want.bytes ||
                got_live != want.live) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display({"%0t: result mismatch status exp %0d got %0d, ",
                            "bytes exp %0d got %0d, live exp %0d got %0d"},
                           $realtime, want.status, got_status, want.bytes, got_bytes,
                           want.live, got_live);
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_allocation_tracking_hash_set NOT OK");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         shadow_keys[i]  = KEY_EMPTY;
         shadow_sizes[i] = '0;
      end
      shadow_live      = 0;
      shadow_tombs     = 0;
      shadow_bytes     = '0;
      shadow_limit_mib = LIMIT_RESET;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed table at the reset limit
      foreach (directed_rows[i])
         send_request(directed_rows[i].mode, directed_rows[i].addr, directed_rows[i].size,
                      directed_rows[i].typed, directed_rows[i].want);

      // random phases, each under its own byte limit
      foreach (phases[p]) begin
         wait_for_results();
         write_limit(phases[p].limit_mib);
         for (int i = 0; i < phases[p].items; i++)
            random_request(phases[p]);
      end

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_allocation_tracking_hash_set OK");
      else
         $display("tb_allocation_tracking_hash_set NOT OK");
      $finish;
   end

endmodule

>>> files.f
rtl/aths_pkg.sv
rtl/aths_slot_store.sv
rtl/aths_probe_ctrl.sv
rtl/allocation_tracking_hash_set.sv
dv/tb_allocation_tracking_hash_set.sv
